// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the receiver core RTL.
// Each macro uses the clk and rst_n of the module that includes it.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define AST_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define AST_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_IMP(label, ante, cons)
`define AST_NXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/mlcd_pkg.sv -----
// ---------------------------------------------------------------------------
// mlcd_pkg
// Constants, codes and controller/datapath interface types of the
// memory-LCD panel receiver core.
// ---------------------------------------------------------------------------
package mlcd_pkg;

    localparam int LINE_BYTES   = 50;
    localparam int PANEL_HEIGHT = 240;
    localparam int PANEL_WIDTH  = 400;
    localparam int TX_BYTES     = 16384;

    localparam int IMG_BYTES = PANEL_HEIGHT * LINE_BYTES;
    localparam int IMG_AW    = $clog2(IMG_BYTES);
    localparam int TX_AW     = $clog2(TX_BYTES);
    localparam int LEN_W     = $clog2(TX_BYTES + 1);
    localparam int PW        = LEN_W + 1;
    localparam int CNT_W     = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int ROW_W     = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
    localparam int XY_W      = 10;

    localparam logic [7:0] MODE_WRITE = 8'h01;
    localparam logic [7:0] MODE_VCOM  = 8'h02;
    localparam logic [7:0] MODE_CLEAR = 8'h04;

    typedef enum logic [2:0] {
        FN_SELECT   = 3'd0,
        FN_DESELECT = 3'd1,
        FN_DATA     = 3'd2,
        FN_QUERY    = 3'd3,
        FN_CLR_CNT  = 3'd4
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RESP,
        ST_PIX_RD,
        ST_PIX_EVAL,
        ST_MODE_RD,
        ST_MODE_APPLY,
        ST_PARSE,
        ST_LINE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic select;
        logic deselect;
        logic push;
        logic ctr_clear;
        logic pix_read;
        logic pix_eval;
        logic mode_read;
        logic mode_apply;
        logic parse_read;
        logic line_load;
        logic copy_read;
        logic copy_write;
        logic pos_skip;
        logic len_clear;
    } cmd_t;

    typedef struct packed {
        logic len_zero;
        logic mode_clear;
        logic mode_write;
        logic parse_more;
        logic line_ok;
        logic copy_last;
    } status_t;

    // line addresses travel LSB first
    function automatic logic [7:0] flip8(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[7 - k] = b[k];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/mlcd_ctrl.sv -----
// ---------------------------------------------------------------------------
// mlcd_ctrl
// Sequencer of the receiver core: decodes commands, walks the transaction
// apply (mode byte, line records, byte copy) and the pixel read.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mlcd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        func,
    input  mlcd_pkg::status_t status,
    output mlcd_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done
);
    import mlcd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != ST_IDLE);
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_RESP;
                    case (func)
                        FN_SELECT:   cmd.select = 1'b1;
                        FN_DESELECT:
                        begin
                            cmd.deselect = 1'b1;
                            state_next   = ST_MODE_RD;
                        end
                        FN_DATA:     cmd.push = 1'b1;
                        FN_QUERY:    state_next = ST_PIX_RD;
                        FN_CLR_CNT:  cmd.ctr_clear = 1'b1;
                        default:     state_next = ST_RESP;
                    endcase
                end
            end
            ST_RESP:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            ST_PIX_RD:
            begin
                cmd.pix_read = 1'b1;
                state_next   = ST_PIX_EVAL;
            end
            ST_PIX_EVAL:
            begin
                cmd.pix_eval = 1'b1;
                state_next   = ST_RESP;
            end
            ST_MODE_RD:
            begin
                if (status.len_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.mode_read = 1'b1;
                    state_next    = ST_MODE_APPLY;
                end
            end
            ST_MODE_APPLY:
            begin
                cmd.mode_apply = 1'b1;
                // clear wins over write
                if (!status.mode_clear && status.mode_write)
                begin
                    state_next = ST_PARSE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PARSE:
            begin
                if (status.parse_more)
                begin
                    cmd.parse_read = 1'b1;
                    state_next     = ST_LINE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_LINE:
            begin
                cmd.line_load = 1'b1;
                if (status.line_ok)
                begin
                    state_next = ST_COPY_RD;
                end
                else
                begin
                    cmd.pos_skip = 1'b1;
                    state_next   = ST_PARSE;
                end
            end
            ST_COPY_RD:
            begin
                cmd.copy_read = 1'b1;
                state_next    = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                cmd.copy_write = 1'b1;
                if (status.copy_last)
                begin
                    cmd.pos_skip = 1'b1;
                    state_next   = ST_PARSE;
                end
                else
                begin
                    state_next = ST_COPY_RD;
                end
            end
            ST_FINISH:
            begin
                cmd.len_clear = 1'b1;
                state_next    = ST_RESP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `AST_IMP(a_done_busy, done, busy)
    `AST_NXT(a_done_idle, done, !busy)
    `AST_NXT(a_accept_busy, start && !busy, busy)

endmodule

// ----- rtl/core/mlcd_datapath.sv -----
// ---------------------------------------------------------------------------
// mlcd_datapath
// Transaction buffer, image memory with per-row valid bits, parse pointers,
// status counters and the pixel read path.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mlcd_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  mlcd_pkg::cmd_t    cmd,
    input  logic [2:0]        func,
    input  logic [7:0]        data_byte,
    input  logic [9:0]        pixel_x,
    input  logic [9:0]        pixel_y,
    output mlcd_pkg::status_t status,
    output logic              pixel_black,
    output logic              vcom_level,
    output logic [31:0]       lines_written,
    output logic [31:0]       clear_count,
    output logic [31:0]       vcom_toggle_count,
    output logic              overflow_flag
);
    import mlcd_pkg::*;

    logic [7:0]             buf_mem [TX_BYTES];
    logic [7:0]             img_mem [IMG_BYTES];
    logic [7:0]             buf_rdata_reg;
    logic [7:0]             img_rdata_reg;
    logic [TX_AW-1:0]       buf_raddr;
    logic                   buf_re;
    logic                   buf_we;
    logic                   buf_full;
    logic [LEN_W-1:0]       len_reg;
    logic [PW-1:0]          pos_reg;
    logic [TX_AW-1:0]       rd_ptr_reg;
    logic [IMG_AW-1:0]      img_waddr_reg;
    logic [IMG_AW-1:0]      pix_addr;
    logic [CNT_W-1:0]       byte_cnt_reg;
    logic [PANEL_HEIGHT-1:0] row_valid_reg;
    logic                   sel_reg;
    logic                   vcom_reg;
    logic                   ovf_reg;
    logic                   black_reg;
    logic                   in_range_reg;
    logic                   row_hit_reg;
    logic [31:0]            lines_reg;
    logic [31:0]            clears_reg;
    logic [31:0]            toggles_reg;
    logic [XY_W-1:0]        x_reg;
    logic [XY_W-1:0]        y_reg;
    logic [7:0]             line_num;
    logic                   line_ok;
    logic [ROW_W-1:0]       line_row;
    logic [ROW_W-1:0]       pix_row;
    logic                   pix_in_range;
    logic                   mode_vcom;
    logic                   mode_clear;
    logic                   mode_write;

    assign buf_full   = (len_reg >= LEN_W'(TX_BYTES));
    assign buf_we     = cmd.push && sel_reg && !buf_full;
    assign buf_re     = cmd.mode_read || cmd.parse_read || cmd.copy_read;
    assign mode_vcom  = ((buf_rdata_reg & MODE_VCOM) != 8'h00);
    assign mode_clear = ((buf_rdata_reg & MODE_CLEAR) != 8'h00);
    assign mode_write = ((buf_rdata_reg & MODE_WRITE) != 8'h00);

    assign line_num = flip8(buf_rdata_reg);
    assign line_ok  = (line_num != 8'd0) && (line_num <= 8'(PANEL_HEIGHT));
    assign line_row = ROW_W'(line_num - 8'd1);

    assign pix_row      = y_reg[ROW_W-1:0];
    assign pix_in_range = ({1'b0, x_reg} < 11'(PANEL_WIDTH))
                       && (y_reg < 10'(PANEL_HEIGHT))
                       && ({1'b0, x_reg[9:3]} < 8'(LINE_BYTES));
    assign pix_addr     = IMG_AW'(pix_row * LINE_BYTES) + IMG_AW'(x_reg[9:3]);

    always_comb
    begin
        buf_raddr = rd_ptr_reg;
        if (cmd.mode_read)
        begin
            buf_raddr = '0;
        end
        else if (cmd.parse_read)
        begin
            buf_raddr = pos_reg[TX_AW-1:0];
        end
    end

    assign status.len_zero   = (len_reg == '0);
    assign status.mode_clear = mode_clear;
    assign status.mode_write = mode_write;
    assign status.parse_more = ((pos_reg + PW'(LINE_BYTES + 1)) < {1'b0, len_reg});
    assign status.line_ok    = line_ok;
    assign status.copy_last  = (byte_cnt_reg == CNT_W'(LINE_BYTES - 1));

    // transaction buffer
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[len_reg[TX_AW-1:0]] <= data_byte;
        end
        if (buf_re)
        begin
            buf_rdata_reg <= buf_mem[buf_raddr];
        end
    end

    // image memory; rows not marked valid read as white
    always_ff @(posedge clk)
    begin
        if (cmd.copy_write)
        begin
            img_mem[img_waddr_reg] <= buf_rdata_reg;
        end
        if (cmd.pix_read && pix_in_range)
        begin
            img_rdata_reg <= img_mem[pix_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (func == FN_QUERY))
        begin
            x_reg <= pixel_x;
            y_reg <= pixel_y;
        end
        if (cmd.pix_read)
        begin
            in_range_reg <= pix_in_range;
            row_hit_reg  <= pix_in_range && row_valid_reg[pix_row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= 1'b0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            vcom_reg      <= 1'b0;
            black_reg     <= 1'b0;
            lines_reg     <= '0;
            clears_reg    <= '0;
            toggles_reg   <= '0;
            row_valid_reg <= '0;
            pos_reg       <= '0;
            rd_ptr_reg    <= '0;
            byte_cnt_reg  <= '0;
            img_waddr_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                black_reg <= 1'b0;
            end
            if (cmd.select)
            begin
                sel_reg <= 1'b1;
                len_reg <= '0;
            end
            if (cmd.deselect)
            begin
                sel_reg <= 1'b0;
            end
            if (cmd.push && sel_reg)
            begin
                if (buf_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    len_reg <= len_reg + LEN_W'(1);
                end
            end
            if (cmd.len_clear)
            begin
                len_reg <= '0;
            end
            if (cmd.ctr_clear)
            begin
                lines_reg   <= '0;
                clears_reg  <= '0;
                toggles_reg <= '0;
            end
            if (cmd.mode_apply)
            begin
                if (mode_vcom != vcom_reg)
                begin
                    vcom_reg    <= mode_vcom;
                    toggles_reg <= toggles_reg + 32'd1;
                end
                if (mode_clear)
                begin
                    row_valid_reg <= '0;
                    clears_reg    <= clears_reg + 32'd1;
                end
                pos_reg <= PW'(1);
            end
            if (cmd.line_load)
            begin
                rd_ptr_reg    <= pos_reg[TX_AW-1:0] + TX_AW'(1);
                byte_cnt_reg  <= '0;
                img_waddr_reg <= IMG_AW'(line_row * LINE_BYTES);
                if (line_ok)
                begin
                    row_valid_reg[line_row] <= 1'b1;
                    lines_reg               <= lines_reg + 32'd1;
                end
            end
            if (cmd.copy_write)
            begin
                byte_cnt_reg  <= byte_cnt_reg + CNT_W'(1);
                rd_ptr_reg    <= rd_ptr_reg + TX_AW'(1);
                img_waddr_reg <= img_waddr_reg + IMG_AW'(1);
            end
            if (cmd.pos_skip)
            begin
                pos_reg <= pos_reg + PW'(LINE_BYTES + 2);
            end
            if (cmd.pix_eval)
            begin
                // stored 0 bit is black, MSB is the leftmost pixel
                black_reg <= in_range_reg && row_hit_reg && !img_rdata_reg[~x_reg[2:0]];
            end
        end
    end

    assign pixel_black       = black_reg;
    assign vcom_level        = vcom_reg;
    assign lines_written     = lines_reg;
    assign clear_count       = clears_reg;
    assign vcom_toggle_count = toggles_reg;
    assign overflow_flag     = ovf_reg;

    `AST_IMP(a_len_bound, 1'b1, len_reg <= LEN_W'(TX_BYTES))
    `AST_IMP(a_copy_addr, cmd.copy_write, 32'(img_waddr_reg) < IMG_BYTES)
    `AST_NXT(a_ctr_clear, cmd.ctr_clear, lines_reg == '0 && clears_reg == '0 && toggles_reg == '0)
    `AST_NXT(a_ovf_sticky, ovf_reg, ovf_reg)

endmodule

// ----- rtl/core/memory_lcd_panel_receiver_core.sv -----
// ---------------------------------------------------------------------------
// memory_lcd_panel_receiver_core
// Panel side of a memory-LCD serial link: buffers a transaction while
// selected, applies it on deselect, answers pixel queries.
// ---------------------------------------------------------------------------
// Usage: drive func/data_byte/pixel_x/pixel_y with start; a transfer happens
// at the edge where start is high and busy is low. Each command gives one
// result: done pulses for one cycle with the result ports valid; pixel_black
// is 1 only for a query on a black pixel, the rest show the state after it.
// Select, data byte, clear counters, unused codes: done in the cycle after
// the transfer; busy stays high through done, and the next transfer follows.
// Pixel query: done after the memory read (PIX_RD) and bit select (PIX_EVAL).
// Deselect walks the buffer through one read port, a read then a write per
// copied byte. An empty buffer goes straight to FINISH; else the mode byte is
// read, and a clear or non-write mode finishes there; else each line record
// is read and its bytes copied (a record with a bad line address is skipped).
// Reset: async, active low; image reads white at once (per-row valid bits,
// no sweep), counters, vcom and overflow cleared. Results cannot be stalled.
// ---------------------------------------------------------------------------
module memory_lcd_panel_receiver_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [7:0]  data_byte,
    input  logic [9:0]  pixel_x,
    input  logic [9:0]  pixel_y,
    output logic        done,
    output logic        pixel_black,
    output logic        vcom_level,
    output logic [31:0] lines_written,
    output logic [31:0] clear_count,
    output logic [31:0] vcom_toggle_count,
    output logic        overflow_flag
);
    import mlcd_pkg::*;

    cmd_t    cmd;
    status_t status;

    mlcd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    mlcd_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .func              (func),
        .data_byte         (data_byte),
        .pixel_x           (pixel_x),
        .pixel_y           (pixel_y),
        .status            (status),
        .pixel_black       (pixel_black),
        .vcom_level        (vcom_level),
        .lines_written     (lines_written),
        .clear_count       (clear_count),
        .vcom_toggle_count (vcom_toggle_count),
        .overflow_flag     (overflow_flag)
    );

endmodule
